// File: sv/kwh_pkg.sv
`default_nettype none
package kwh_pkg;

  // Default sizes of the line stores
  localparam int unsigned DefMaxWidth  = 2048;
  localparam int unsigned DefMaxRadius = 8;

  // Field and datapath widths
  localparam int unsigned NCh      = 3;
  localparam int unsigned ChW      = 8;
  localparam int unsigned PixW     = NCh * ChW;
  localparam int unsigned RadW     = 4;
  localparam int unsigned ColW     = 12;
  localparam int unsigned RowW     = 16;
  localparam int unsigned NW       = 9;   // (R+1)^2 for R up to 15
  localparam int unsigned SW       = 16;  // sum of one channel over a quadrant
  localparam int unsigned SSW      = 24;  // sum of squares of one channel
  localparam int unsigned PaW      = 33;  // n * sum of squares
  localparam int unsigned PbW      = 32;  // sum squared
  localparam int unsigned VW       = 35;  // variance summed over channels
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgRadius = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHeight = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgColor  = 2'd3;

  // Commands
  localparam logic CmdPush  = 1'b0;
  localparam logic CmdDrain = 1'b1;

  // Control of the quadrant cells
  typedef struct packed {
    logic       clr;
    logic       acc;
    logic [1:0] acc_quad;
    logic       prod;
    logic       accv;
    logic [1:0] ch;
  } kwh_cell_ctl_t;

  // Quadrant candidate handed along the cell chain
  typedef struct packed {
    logic [VW-1:0]           var_sum;
    logic [NCh-1:0][SW-1:0]  sum;
    logic [1:0]              quad;
  } kwh_cand_t;

endpackage
`default_nettype wire

// File: sv/kwh_in_if.sv
`default_nettype none
interface kwh_in_if import kwh_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           command;
  logic [ChW-1:0] in_chan0;
  logic [ChW-1:0] in_chan1;
  logic [ChW-1:0] in_chan2;

  modport source (output valid, command, in_chan0, in_chan1, in_chan2, input ready);
  modport sink   (input valid, command, in_chan0, in_chan1, in_chan2, output ready);
endinterface
`default_nettype wire

// File: sv/kwh_out_if.sv
`default_nettype none
interface kwh_out_if import kwh_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [ChW-1:0] out_chan0;
  logic [ChW-1:0] out_chan1;
  logic [ChW-1:0] out_chan2;
  logic [1:0]     chosen_quadrant;
  logic           frame_end;

  modport source (output valid, out_chan0, out_chan1, out_chan2, chosen_quadrant, frame_end,
                  input ready);
  modport sink   (input valid, out_chan0, out_chan1, out_chan2, chosen_quadrant, frame_end,
                  output ready);
endinterface
`default_nettype wire

// File: sv/kuwahara_filter_stream_core.sv
`default_nettype none
// Streaming four-quadrant Kuwahara filter. Pixels enter in raster order on in_i
// (command push) and are kept in 2*MAX_RADIUS+2 line stores; each output pixel is
// the rounded mean of the least-variance quadrant of (R+1)x(R+1) edge-clamped
// pixels, given in raster order once its pixels have arrived; drain words flush
// the rest of a frame. A new push or drain is accepted only once the last is through.
// For one that gives an output, the quadrant sweep reads the single line-store
// read port once per pixel, four accumulator cells in a chain pick the winner,
// and a 16-step divider forms the means. The line stores need no clearing after
// reset. Configuration writes restart the frame; the user must see that they are
// taken only while idle, as the block itself does not enforce it.
module kuwahara_filter_stream_core import kwh_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_RADIUS = DefMaxRadius
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  kwh_in_if.sink              in_i,
  kwh_out_if.source           out_o
);

  localparam int unsigned NSLOT   = 2 * MAX_RADIUS + 2;
  localparam int unsigned SlotW   = $clog2(NSLOT);
  localparam int unsigned Depth   = NSLOT * MAX_WIDTH;
  localparam int unsigned AW      = $clog2(Depth);
  localparam int unsigned FwReset = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam logic signed [7:0] NslotS = 8'(NSLOT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_VAR   = 3'd4;
  localparam logic [2:0] S_CHAIN = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]       state_q;
  logic [RadW-1:0]  rad_q;
  logic [ColW-1:0]  fw_q, in_col_q, out_col_q;
  logic [RowW-1:0]  fh_q, in_row_q, out_row_q;
  logic             color_q, frame_in_q;
  logic [SlotW-1:0] in_slot_q, out_slot_q;
  logic [NW-1:0]    n_q;
  logic [1:0]       qc_q, vc_q;
  logic [RadW-1:0]  jc_q, ic_q;
  logic             ph_q;
  logic [2:0]       cc_q;
  logic             rvld_q;
  logic [1:0]       rtag_q;
  logic [PixW-1:0]  rdata_q;
  logic [PixW-1:0]  mem [Depth];
  logic             out_valid_q, frame_end_q;
  logic [ChW-1:0]   och0_q, och1_q, och2_q;
  logic [1:0]       oquad_q;

  logic             accept, push, ready_nx, last_rd, out_free;
  logic [ColW-1:0]  wmax;
  logic [RowW-1:0]  hmax, dr;
  logic [ColW-1:0]  dc;
  logic [RowW:0]    dr_w;
  logic [ColW:0]    dc_w;
  logic signed [5:0]  roff, coff, dlt;
  logic signed [17:0] row_s, drow;
  logic signed [13:0] col_s;
  logic [RowW-1:0]  row_c;
  logic [ColW-1:0]  col_c;
  logic signed [7:0]  slot_s, slot_w;
  logic [SlotW-1:0] rd_slot;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [1:0]       nch_m1;
  kwh_cell_ctl_t    ctl;
  kwh_cand_t        cand_w [4];
  logic             div_start, div_done;
  logic [NCh-1:0][ChW-1:0] mean;

  assign accept   = in_i.valid && in_i.ready;
  assign push     = accept && (in_i.command == CmdPush);
  assign in_i.ready = (state_q == S_IDLE);
  assign wmax     = fw_q - 1'b1;
  assign hmax     = fh_q - 1'b1;
  assign nch_m1   = color_q ? 2'd2 : 2'd0;
  assign out_free = !out_valid_q || out_o.ready;

  // Readiness of the next output pixel
  always_comb begin
    dr_w = {1'b0, out_row_q} + (RowW+1)'(rad_q);
    dc_w = {1'b0, out_col_q} + (ColW+1)'(rad_q);
    dr   = (dr_w > {1'b0, hmax}) ? hmax : dr_w[RowW-1:0];
    dc   = (dc_w > {1'b0, wmax}) ? wmax : dc_w[ColW-1:0];
    ready_nx = frame_in_q || (in_row_q > dr) || (in_row_q == dr && in_col_q > dc);
  end

  // Sweep address: clamp row and column, map row to its line store
  always_comb begin
    roff = (qc_q < 2'd2) ? $signed({2'b0, jc_q}) - $signed({2'b0, rad_q})
                         : $signed({2'b0, jc_q});
    coff = (qc_q == 2'd0 || qc_q == 2'd3) ? $signed({2'b0, ic_q}) - $signed({2'b0, rad_q})
                                          : $signed({2'b0, ic_q});
    row_s = $signed({2'b0, out_row_q}) + 18'(roff);
    col_s = $signed({2'b0, out_col_q}) + 14'(coff);
    if (row_s < 0) row_c = '0;
    else if (row_s > $signed({2'b0, hmax})) row_c = hmax;
    else row_c = row_s[RowW-1:0];
    if (col_s < 0) col_c = '0;
    else if (col_s > $signed({2'b0, wmax})) col_c = wmax;
    else col_c = col_s[ColW-1:0];
    drow   = $signed({2'b0, row_c}) - $signed({2'b0, out_row_q});
    dlt    = drow[5:0];
    slot_s = $signed(8'(out_slot_q)) + 8'(dlt);
    if (slot_s < 0) slot_w = slot_s + NslotS;
    else if (slot_s >= NslotS) slot_w = slot_s - NslotS;
    else slot_w = slot_s;
    rd_slot = slot_w[SlotW-1:0];
    rd_addr = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(col_c);
    wr_addr = AW'(in_slot_q) * AW'(MAX_WIDTH) + AW'(in_col_q);
    last_rd = (qc_q == 2'd3) && (jc_q == rad_q) && (ic_q == rad_q);
  end

  // Line stores
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_addr] <= {in_i.in_chan2, in_i.in_chan1, in_i.in_chan0};
    end
    rdata_q <= mem[rd_addr];
    n_q     <= NW'((RadW+1)'(rad_q) + 1'b1) * NW'((RadW+1)'(rad_q) + 1'b1);
  end

  // Cell controls
  always_comb begin
    ctl.clr      = (state_q == S_CHECK) && ready_nx;
    ctl.acc      = rvld_q;
    ctl.acc_quad = rtag_q;
    ctl.prod     = (state_q == S_VAR) && !ph_q;
    ctl.accv     = (state_q == S_VAR) && ph_q;
    ctl.ch       = vc_q;
  end

  assign div_start = (state_q == S_CHAIN) && (cc_q == 3'd4);

  // Chain of quadrant cells
  for (genvar k = 0; k < 4; k++) begin : g_cell
    kwh_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .idx_i  (2'(k)),
      .pix_i  (rdata_q),
      .n_i    (n_q),
      .cand_i (cand_w[(k == 0) ? 0 : k - 1]),
      .cand_o (cand_w[k])
    );
  end

  kwh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .n_i     (n_q),
    .sum_i   (cand_w[3].sum),
    .done_o  (div_done),
    .mean_o  (mean)
  );

  // Sequencer, positions and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rad_q       <= RadW'(2);
      fw_q        <= ColW'(FwReset);
      fh_q        <= RowW'(480);
      color_q     <= 1'b0;
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      frame_in_q  <= 1'b0;
      qc_q        <= '0;
      jc_q        <= '0;
      ic_q        <= '0;
      vc_q        <= '0;
      ph_q        <= 1'b0;
      cc_q        <= '0;
      rvld_q      <= 1'b0;
      rtag_q      <= '0;
      out_valid_q <= 1'b0;
      och0_q      <= '0;
      och1_q      <= '0;
      och2_q      <= '0;
      oquad_q     <= '0;
      frame_end_q <= 1'b0;
    end else begin
      rvld_q <= (state_q == S_SWEEP);
      rtag_q <= qc_q;
      if (out_valid_q && out_o.ready && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgRadius: rad_q <= ({1'b0, cfg_data_i[RadW-1:0]} > 5'(MAX_RADIUS))
                              ? RadW'(MAX_RADIUS) : cfg_data_i[RadW-1:0];
          CfgWidth: begin
            if (cfg_data_i[ColW-1:0] == '0) fw_q <= ColW'(1);
            else if (14'(cfg_data_i[ColW-1:0]) > 14'(MAX_WIDTH)) fw_q <= ColW'(MAX_WIDTH);
            else fw_q <= cfg_data_i[ColW-1:0];
          end
          CfgHeight: fh_q <= (cfg_data_i == '0) ? RowW'(1) : cfg_data_i;
          CfgColor:  color_q <= cfg_data_i[0];
          default: ;
        endcase
        // Restart the frame
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        frame_in_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_CHECK;
          end
          if (push) begin
            // Drop what is left of a finished frame
            if (frame_in_q) begin
              out_col_q  <= '0;
              out_row_q  <= '0;
              out_slot_q <= '0;
              if (!(in_col_q == wmax && in_row_q == hmax)) begin
                frame_in_q <= 1'b0;
              end
            end
            if (in_col_q == wmax) begin
              in_col_q <= '0;
              if (in_row_q == hmax) begin
                in_row_q   <= '0;
                in_slot_q  <= '0;
                frame_in_q <= 1'b1;
              end else begin
                in_row_q  <= in_row_q + 1'b1;
                in_slot_q <= ({1'b0, in_slot_q} == (SlotW+1)'(NSLOT - 1))
                             ? '0 : in_slot_q + 1'b1;
              end
            end else begin
              in_col_q <= in_col_q + 1'b1;
            end
          end
        end
        S_CHECK: begin
          qc_q <= '0;
          jc_q <= '0;
          ic_q <= '0;
          state_q <= ready_nx ? S_SWEEP : S_IDLE;
        end
        S_SWEEP: begin
          // Advance the quadrant sweep
          if (ic_q == rad_q) begin
            ic_q <= '0;
            if (jc_q == rad_q) begin
              jc_q <= '0;
              qc_q <= qc_q + 1'b1;
            end else begin
              jc_q <= jc_q + 1'b1;
            end
          end else begin
            ic_q <= ic_q + 1'b1;
          end
          if (last_rd) begin
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          vc_q    <= '0;
          ph_q    <= 1'b0;
          state_q <= S_VAR;
        end
        S_VAR: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (vc_q == nch_m1) begin
              cc_q    <= '0;
              state_q <= S_CHAIN;
            end else begin
              vc_q <= vc_q + 1'b1;
            end
          end
        end
        S_CHAIN: begin
          cc_q <= cc_q + 1'b1;
          if (cc_q == 3'd4) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            och0_q      <= mean[0];
            och1_q      <= color_q ? mean[1] : '0;
            och2_q      <= color_q ? mean[2] : '0;
            oquad_q     <= cand_w[3].quad;
            frame_end_q <= (out_col_q == wmax) && (out_row_q == hmax);
            if (out_col_q == wmax) begin
              out_col_q <= '0;
              if (out_row_q == hmax) begin
                out_row_q  <= '0;
                out_slot_q <= '0;
                frame_in_q <= 1'b0;
              end else begin
                out_row_q  <= out_row_q + 1'b1;
                out_slot_q <= ({1'b0, out_slot_q} == (SlotW+1)'(NSLOT - 1))
                              ? '0 : out_slot_q + 1'b1;
              end
            end else begin
              out_col_q <= out_col_q + 1'b1;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.out_chan0       = och0_q;
  assign out_o.out_chan1       = och1_q;
  assign out_o.out_chan2       = och2_q;
  assign out_o.chosen_quadrant = oquad_q;
  assign out_o.frame_end       = frame_end_q;

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, in_slot_q} < (SlotW+1)'(NSLOT)) && ({1'b0, out_slot_q} < (SlotW+1)'(NSLOT)))
    else $error("line store slot out of range");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_col_q < fw_q) && (out_col_q < fw_q))
    else $error("column beyond frame width");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_OUT)
    else $error("output word loaded outside output step");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("divider finished while not awaited");

endmodule
`default_nettype wire

// File: sv/kwh_cell.sv
`default_nettype none
module kwh_cell import kwh_pkg::*; (
  input  logic          clk_i,
  input  kwh_cell_ctl_t ctl_i,
  input  logic [1:0]    idx_i,
  input  logic [PixW-1:0] pix_i,
  input  logic [NW-1:0] n_i,
  input  kwh_cand_t     cand_i,
  output kwh_cand_t     cand_o
);

  logic [SW-1:0]  sum_q [NCh];
  logic [SSW-1:0] sq_q  [NCh];
  logic [PaW-1:0] pa_q;
  logic [PbW-1:0] pb_q;
  logic [VW-1:0]  var_q;
  kwh_cand_t      cand_q;
  kwh_cand_t      own;
  logic           take_own;

  // Own candidate; the first cell always starts the chain
  always_comb begin
    own.var_sum = var_q;
    for (int c = 0; c < NCh; c++) begin
      own.sum[c] = sum_q[c];
    end
    own.quad = idx_i;
    take_own = (idx_i == 2'd0) || (var_q < cand_i.var_sum);
  end

  // Accumulate quadrant pixels, then form the variance channel by channel
  always_ff @(posedge clk_i) begin
    if (ctl_i.clr) begin
      for (int c = 0; c < NCh; c++) begin
        sum_q[c] <= '0;
        sq_q[c]  <= '0;
      end
      var_q <= '0;
    end else if (ctl_i.acc && ctl_i.acc_quad == idx_i) begin
      for (int c = 0; c < NCh; c++) begin
        sum_q[c] <= sum_q[c] + SW'(pix_i[c*ChW +: ChW]);
        sq_q[c]  <= sq_q[c] + SSW'(pix_i[c*ChW +: ChW]) * SSW'(pix_i[c*ChW +: ChW]);
      end
    end else if (ctl_i.accv) begin
      var_q <= var_q + VW'(pa_q - PaW'(pb_q));
    end
    if (ctl_i.prod) begin
      pa_q <= PaW'(n_i) * PaW'(sq_q[ctl_i.ch]);
      pb_q <= PbW'(sum_q[ctl_i.ch]) * PbW'(sum_q[ctl_i.ch]);
    end
    // Pass the better of own and neighbor, earlier quadrant on ties
    cand_q <= take_own ? own : cand_i;
  end

  assign cand_o = cand_q;

endmodule
`default_nettype wire

// File: sv/kwh_div.sv
`default_nettype none
module kwh_div import kwh_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [NW-1:0]          n_i,
  input  logic [NCh-1:0][SW-1:0] sum_i,
  output logic                   done_o,
  output logic [NCh-1:0][ChW-1:0] mean_o
);

  localparam int unsigned CntW = $clog2(SW);

  logic                    busy_q, fin_q, done_q;
  logic [CntW-1:0]         cnt_q;
  logic [SW-1:0]           dvd_q  [NCh];
  logic [NW-1:0]           rem_q  [NCh];
  logic [NCh-1:0][ChW-1:0] mean_q;
  logic [NW:0]             trial  [NCh];
  logic                    qbit   [NCh];
  logic [NW-1:0]           rem_d  [NCh];
  logic [NW:0]             r2     [NCh];
  logic                    up     [NCh];
  logic [SW:0]             qr     [NCh];

  // One restoring step per cycle, all channels side by side
  always_comb begin
    for (int c = 0; c < NCh; c++) begin
      trial[c] = {rem_q[c], dvd_q[c][SW-1]};
      qbit[c]  = trial[c] >= {1'b0, n_i};
      rem_d[c] = qbit[c] ? NW'(trial[c] - {1'b0, n_i}) : trial[c][NW-1:0];
      r2[c]    = {rem_q[c], 1'b0};
      up[c]    = (r2[c] > {1'b0, n_i}) || (r2[c] == {1'b0, n_i} && dvd_q[c][0]);
      qr[c]    = {1'b0, dvd_q[c]} + (SW+1)'(up[c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(SW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Shift quotient bits in; round to nearest, ties to even
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCh; c++) begin
      if (start_i) begin
        dvd_q[c] <= sum_i[c];
        rem_q[c] <= '0;
      end else if (busy_q) begin
        dvd_q[c] <= {dvd_q[c][SW-2:0], qbit[c]};
        rem_q[c] <= rem_d[c];
      end else if (fin_q) begin
        mean_q[c] <= (qr[c] > (SW+1)'(255)) ? ChW'(255) : qr[c][ChW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign mean_o = mean_q;

endmodule
`default_nettype wire
